FILE: sv/pmct_pkg.sv
`timescale 1ns / 1ps

package pmct_pkg;

   localparam int BYTE_W      = 8;
   localparam int SCREEN_W    = 13;
   localparam int CURSOR_W    = 5;
   localparam int POINTER_W   = 12;
   localparam int MOVE_W      = 9;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = SCREEN_W;

   // signed width that holds pointer +/- a 9-bit delta and screen - cursor
   localparam int SUM_W = POINTER_W + 2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [POINTER_W-1:0] POINTER_MAX = '1;

   // header byte layout
   localparam int LEFT_BIT   = 0;
   localparam int RIGHT_BIT  = 1;
   localparam int MIDDLE_BIT = 2;
   localparam int SYNC_BIT   = 3;
   localparam int X_SIGN_BIT = 4;
   localparam int Y_SIGN_BIT = 5;
   localparam int X_OVF_BIT  = 6;
   localparam int Y_OVF_BIT  = 7;

   localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RESET  = SCREEN_W'(800);
   localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RESET = SCREEN_W'(600);
   localparam logic [CURSOR_W-1:0] CURSOR_WIDTH_RESET  = CURSOR_W'(16);
   localparam logic [CURSOR_W-1:0] CURSOR_HEIGHT_RESET = CURSOR_W'(14);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SCREEN_WIDTH  = CSR_INDEX_W'(0),
      CSR_SCREEN_HEIGHT = CSR_INDEX_W'(1),
      CSR_CURSOR_WIDTH  = CSR_INDEX_W'(2),
      CSR_CURSOR_HEIGHT = CSR_INDEX_W'(3)
   } csr_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0] header;
      logic [BYTE_W-1:0] x_byte;
      logic [BYTE_W-1:0] y_byte;
   } packet_type;

   typedef struct packed {
      logic [SCREEN_W-1:0] screen_width;
      logic [SCREEN_W-1:0] screen_height;
      logic [CURSOR_W-1:0] cursor_width;
      logic [CURSOR_W-1:0] cursor_height;
   } config_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

FILE: sv/pmct_front.sv
`timescale 1ns / 1ps

module pmct_front
   import pmct_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BYTE_W-1:0] req_data_byte,
   input  queue_status_type  queue_status,
   output logic              push_valid,
   output packet_type        push_packet
);

   typedef enum logic [1:0] {
      WAIT_HEADER = 2'd0,
      WAIT_X      = 2'd1,
      WAIT_Y      = 2'd2
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] header_ff, header_in;
   logic [BYTE_W-1:0] x_byte_ff, x_byte_in;
   logic              take;

   assign req_ready = !queue_status.full;
   assign take      = req_valid && req_ready;

   always_comb begin
      phase_in   = phase_ff;
      header_in  = header_ff;
      x_byte_in  = x_byte_ff;
      push_valid = 1'b0;
      if (take) begin
         unique case (phase_ff)
            WAIT_X: begin
               x_byte_in = req_data_byte;
               phase_in  = WAIT_Y;
            end
            WAIT_Y: begin
               push_valid = 1'b1;
               phase_in   = WAIT_HEADER;
            end
            default: begin
               // drop bytes without the sync bit while hunting for a header
               if (req_data_byte[SYNC_BIT]) begin
                  header_in = req_data_byte;
                  phase_in  = WAIT_X;
               end else begin
                  phase_in = WAIT_HEADER;
               end
            end
         endcase
      end
   end

   assign push_packet = '{header: header_ff, x_byte: x_byte_ff, y_byte: req_data_byte};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= WAIT_HEADER;
         header_ff <= '0;
         x_byte_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         header_ff <= header_in;
         x_byte_ff <= x_byte_in;
      end
   end

endmodule

FILE: sv/pmct_queue.sv
`timescale 1ns / 1ps

module pmct_queue
   import pmct_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  packet_type       push_packet,
   input  logic             pop,
   output packet_type       head_packet,
   output queue_status_type status
);

   packet_type             slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push_valid && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_packet  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_packet;
      end
   end

endmodule

FILE: sv/pmct_back.sv
`timescale 1ns / 1ps

module pmct_back
   import pmct_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  config_type                  cfg,
   input  queue_status_type            queue_status,
   input  packet_type                  head_packet,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_left_button,
   output logic                        rsp_right_button,
   output logic                        rsp_middle_button,
   output logic signed [MOVE_W-1:0]    rsp_move_x,
   output logic signed [MOVE_W-1:0]    rsp_move_y,
   output logic                        rsp_x_overflow,
   output logic                        rsp_y_overflow,
   output logic        [POINTER_W-1:0] rsp_pointer_x,
   output logic        [POINTER_W-1:0] rsp_pointer_y
);

   function automatic logic [POINTER_W-1:0] clamp_axis(
      input logic signed [SUM_W-1:0]  sum,
      input logic        [SCREEN_W-1:0] screen,
      input logic        [CURSOR_W-1:0] cursor
   );
      logic signed [SUM_W-1:0]     limit;
      logic        [POINTER_W-1:0] lim;
      logic        [POINTER_W-1:0] result;
      limit = $signed({{(SUM_W-SCREEN_W){1'b0}}, screen})
            - $signed({{(SUM_W-CURSOR_W){1'b0}}, cursor});
      if (limit < 0) begin
         lim = '0;
      end else if (limit > $signed({{(SUM_W-POINTER_W){1'b0}}, POINTER_MAX})) begin
         lim = POINTER_MAX;
      end else begin
         lim = limit[POINTER_W-1:0];
      end
      if (sum < 0) begin
         result = '0;
      end else if (sum > $signed({{(SUM_W-POINTER_W){1'b0}}, lim})) begin
         result = lim;
      end else begin
         result = sum[POINTER_W-1:0];
      end
      return result;
   endfunction

   logic [POINTER_W-1:0]     cursor_col_ff, cursor_col_in;
   logic [POINTER_W-1:0]     cursor_row_ff, cursor_row_in;
   logic                     valid_ff, valid_in;
   logic                     overflow;
   logic signed [MOVE_W-1:0] dx;
   logic signed [MOVE_W-1:0] dy;
   logic signed [SUM_W-1:0]  sum_x;
   logic signed [SUM_W-1:0]  sum_y;

   logic                        left_ff, right_ff, middle_ff;
   logic signed [MOVE_W-1:0]    move_x_ff, move_y_ff;
   logic                        x_ovf_ff, y_ovf_ff;

   // output register empty or being drained this cycle
   assign pop = !queue_status.empty && (!valid_ff || rsp_ready);

   assign overflow = head_packet.header[X_OVF_BIT] || head_packet.header[Y_OVF_BIT];
   assign dx = overflow ? '0 : $signed({head_packet.header[X_SIGN_BIT], head_packet.x_byte});
   assign dy = overflow ? '0 : $signed({head_packet.header[Y_SIGN_BIT], head_packet.y_byte});

   // row runs downward, so subtract the upward delta
   assign sum_x = $signed({{(SUM_W-POINTER_W){1'b0}}, cursor_col_ff}) + SUM_W'(dx);
   assign sum_y = $signed({{(SUM_W-POINTER_W){1'b0}}, cursor_row_ff}) - SUM_W'(dy);

   always_comb begin
      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      if (pop && !overflow) begin
         cursor_col_in = clamp_axis(sum_x, cfg.screen_width, cfg.cursor_width);
         cursor_row_in = clamp_axis(sum_y, cfg.screen_height, cfg.cursor_height);
      end
      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         cursor_col_ff <= '0;
         cursor_row_ff <= '0;
      end else begin
         valid_ff      <= valid_in;
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         left_ff   <= head_packet.header[LEFT_BIT];
         right_ff  <= head_packet.header[RIGHT_BIT];
         middle_ff <= head_packet.header[MIDDLE_BIT];
         move_x_ff <= dx;
         move_y_ff <= dy;
         x_ovf_ff  <= head_packet.header[X_OVF_BIT];
         y_ovf_ff  <= head_packet.header[Y_OVF_BIT];
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_left_button   = left_ff;
   assign rsp_right_button  = right_ff;
   assign rsp_middle_button = middle_ff;
   assign rsp_move_x        = move_x_ff;
   assign rsp_move_y        = move_y_ff;
   assign rsp_x_overflow    = x_ovf_ff;
   assign rsp_y_overflow    = y_ovf_ff;
   assign rsp_pointer_x     = cursor_col_ff;
   assign rsp_pointer_y     = cursor_row_ff;

endmodule

FILE: sv/ps2_mouse_packet_cursor_tracker_unit.sv
`timescale 1ns / 1ps

// PS/2 mouse packet decoder with a clamped cursor position.
// req_* carries one raw mouse byte per transfer. The front end hunts for a
// header (sync bit 3 set, other bytes dropped), gathers the X and Y bytes,
// and pushes each complete packet into a two-entry queue.
// The back end pops one packet per cycle while its output register is free or
// being drained, decodes buttons, 9-bit deltas and overflow flags, moves the
// cursor (X adds, Y subtracts), clamps both axes to 0 .. screen size less
// cursor size (saturated to 0 .. 4095), and holds the result in an output register
// on rsp_*. On overflow the cursor holds still and the reported deltas are zero.
// Throughput: one byte per cycle while the queue is not full; a packet needs
// three byte transfers, then passes through the queue and the output register to rsp_valid.
// csr_* writes screen_width (0), screen_height (1), cursor_width (2) and
// cursor_height (3); other indexes are ignored. csr_ready is always high.
// Reset (synchronous) clears the byte phase, queue, output valid and cursor
// to zero, and loads the config defaults 800 x 600 with a 16 x 14 cursor.
// When rsp_ready is low, the output register holds; packets pile up in the
// queue, and req_ready drops once the queue is full.
module ps2_mouse_packet_cursor_tracker_unit
   import pmct_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic        [BYTE_W-1:0]    req_data_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_left_button,
   output logic                        rsp_right_button,
   output logic                        rsp_middle_button,
   output logic signed [MOVE_W-1:0]    rsp_move_x,
   output logic signed [MOVE_W-1:0]    rsp_move_y,
   output logic                        rsp_x_overflow,
   output logic                        rsp_y_overflow,
   output logic        [POINTER_W-1:0] rsp_pointer_x,
   output logic        [POINTER_W-1:0] rsp_pointer_y,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic        [CSR_INDEX_W-1:0] csr_index,
   input  logic        [CSR_DATA_W-1:0]  csr_wdata
);

   config_type       cfg_ff, cfg_in;
   queue_status_type queue_status;
   packet_type       push_packet;
   packet_type       head_packet;
   logic             push_valid;
   logic             pop;

   // configuration registers: accept a write every cycle
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:  cfg_in.screen_width  = csr_wdata;
            CSR_SCREEN_HEIGHT: cfg_in.screen_height = csr_wdata;
            CSR_CURSOR_WIDTH:  cfg_in.cursor_width  = csr_wdata[CURSOR_W-1:0];
            CSR_CURSOR_HEIGHT: cfg_in.cursor_height = csr_wdata[CURSOR_W-1:0];
            default: ; // drop writes to unmapped indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width  <= SCREEN_WIDTH_RESET;
         cfg_ff.screen_height <= SCREEN_HEIGHT_RESET;
         cfg_ff.cursor_width  <= CURSOR_WIDTH_RESET;
         cfg_ff.cursor_height <= CURSOR_HEIGHT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end: byte framing
   pmct_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .queue_status  (queue_status),
      .push_valid    (push_valid),
      .push_packet   (push_packet)
   );

   // packet queue between framing and cursor update
   pmct_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (push_valid),
      .push_packet (push_packet),
      .pop         (pop),
      .head_packet (head_packet),
      .status      (queue_status)
   );

   // back end: decode, move and clamp, output register
   pmct_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .queue_status      (queue_status),
      .head_packet       (head_packet),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_left_button   (rsp_left_button),
      .rsp_right_button  (rsp_right_button),
      .rsp_middle_button (rsp_middle_button),
      .rsp_move_x        (rsp_move_x),
      .rsp_move_y        (rsp_move_y),
      .rsp_x_overflow    (rsp_x_overflow),
      .rsp_y_overflow    (rsp_y_overflow),
      .rsp_pointer_x     (rsp_pointer_x),
      .rsp_pointer_y     (rsp_pointer_y)
   );

endmodule

FILE: sv/pmct_checker.sv
`timescale 1ns / 1ps

module pmct_checker
   import pmct_pkg::*;
(
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_left_button,
   input logic                        rsp_right_button,
   input logic                        rsp_middle_button,
   input logic signed [MOVE_W-1:0]    rsp_move_x,
   input logic signed [MOVE_W-1:0]    rsp_move_y,
   input logic                        rsp_x_overflow,
   input logic                        rsp_y_overflow,
   input logic        [POINTER_W-1:0] rsp_pointer_x,
   input logic        [POINTER_W-1:0] rsp_pointer_y
);

   // no result survives reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // a stalled result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_pointer_x) && $stable(rsp_pointer_y)
         && $stable(rsp_move_x) && $stable(rsp_move_y)
         && $stable(rsp_left_button) && $stable(rsp_right_button)
         && $stable(rsp_middle_button) && $stable(rsp_x_overflow)
         && $stable(rsp_y_overflow))
      else $error("result payload changed while stalled");

   // overflowed packets report no movement
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_x_overflow || rsp_y_overflow) |-> rsp_move_x == '0 && rsp_move_y == '0)
      else $error("nonzero delta on overflow");

   // input backpressure only comes from a stalled output
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with empty output register");

endmodule

bind ps2_mouse_packet_cursor_tracker_unit pmct_checker u_pmct_checker (.*);

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import pmct_pkg::*;

   localparam int CYCLE_LIMIT    = 400000;
   localparam int SEGMENTS       = 6;
   localparam int SEGMENT_BYTES  = 270;
   localparam int DRIFT_PERIOD   = 24;
   localparam int CSR_REG_COUNT  = 4;
   localparam int SETTLE_CYCLES  = 4;
   localparam int DIRECTED_COUNT = 28;

   typedef enum logic [1:0] {WAIT_HEADER, WAIT_X, WAIT_Y} packet_phase_type;
   typedef enum {DRIFT_NONE, DRIFT_UP, DRIFT_DOWN} drift_type;

   // One decoded packet as it shows up on the rsp_* side.
   typedef struct packed {
      logic                 left;
      logic                 right;
      logic                 middle;
      logic [MOVE_W-1:0]    move_x;
      logic [MOVE_W-1:0]    move_y;
      logic                 x_ovf;
      logic                 y_ovf;
      logic [POINTER_W-1:0] px;
      logic [POINTER_W-1:0] py;
   } mouse_report_type;

   // One byte of the directed table; pinned rows carry a hand-written report.
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              pinned;
      mouse_report_type  want;
   } directed_row_type;

   localparam mouse_report_type NO_REPORT = '0;

   // Directed bytes, starting from the reset cursor (0, 0) and the default
   // 800 x 600 screen with a 16 x 14 cursor (limits 784 and 586).
   // Report layout: {L, R, M}, move_x, move_y, {x_ovf, y_ovf}, col, row.
   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // sync bit clear while hunting: dropped
      {8'hF7, 1'b0, NO_REPORT},
      // all buttons, largest +x, y up past the top edge
      {8'h0F, 1'b0, NO_REPORT},
      {8'hFF, 1'b0, NO_REPORT},
      {8'h7F, 1'b1, {3'b111, 9'h0FF, 9'h07F, 2'b00, 12'd255, 12'd0}},
      // most negative y moves the row down by 256
      {8'h28, 1'b0, NO_REPORT},
      {8'hFF, 1'b0, NO_REPORT},
      {8'h00, 1'b1, {3'b000, 9'h0FF, 9'h100, 2'b00, 12'd510, 12'd256}},
      {8'h08, 1'b0, NO_REPORT},
      {8'hFF, 1'b0, NO_REPORT},
      {8'hFF, 1'b1, {3'b000, 9'h0FF, 9'h0FF, 2'b00, 12'd765, 12'd1}},
      // column runs into the right edge
      {8'h08, 1'b0, NO_REPORT},
      {8'hFF, 1'b0, NO_REPORT},
      {8'h00, 1'b1, {3'b000, 9'h0FF, 9'h000, 2'b00, 12'd784, 12'd1}},
      // both sign bits with zero bytes: -256 on each axis
      {8'h38, 1'b0, NO_REPORT},
      {8'h00, 1'b0, NO_REPORT},
      {8'h00, 1'b1, {3'b000, 9'h100, 9'h100, 2'b00, 12'd528, 12'd257}},
      // overflow on both axes: no move, deltas reported as zero
      {8'hC8, 1'b0, NO_REPORT},
      {8'h7F, 1'b0, NO_REPORT},
      {8'h7F, 1'b1, {3'b000, 9'h000, 9'h000, 2'b11, 12'd528, 12'd257}},
      // x overflow alone, left and middle held
      {8'h4D, 1'b0, NO_REPORT},
      {8'h55, 1'b0, NO_REPORT},
      {8'hAA, 1'b1, {3'b101, 9'h000, 9'h000, 2'b10, 12'd528, 12'd257}},
      // y overflow alone, right held
      {8'h9A, 1'b0, NO_REPORT},
      {8'h33, 1'b0, NO_REPORT},
      {8'hCC, 1'b1, {3'b010, 9'h000, 9'h000, 2'b01, 12'd528, 12'd257}},
      // data bytes that look like header and noise are still taken as data
      {8'h08, 1'b0, NO_REPORT},
      {8'h08, 1'b0, NO_REPORT},
      {8'hF7, 1'b0, NO_REPORT}
   };

   logic                   clock         = 1'b0;
   logic                   reset         = 1'b1;
   logic                   req_valid     = 1'b0;
   logic                   req_ready;
   logic [BYTE_W-1:0]      req_data_byte = '0;
   logic                   rsp_valid;
   logic                   rsp_ready     = 1'b0;
   logic                   rsp_left_button;
   logic                   rsp_right_button;
   logic                   rsp_middle_button;
   logic signed [MOVE_W-1:0] rsp_move_x;
   logic signed [MOVE_W-1:0] rsp_move_y;
   logic                   rsp_x_overflow;
   logic                   rsp_y_overflow;
   logic [POINTER_W-1:0]   rsp_pointer_x;
   logic [POINTER_W-1:0]   rsp_pointer_y;
   logic                   csr_valid     = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index     = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata     = '0;

   // Shadow copy of the decoder: packet phase, held bytes, cursor and config.
   packet_phase_type       pkt_phase = WAIT_HEADER;
   logic [BYTE_W-1:0]      held_header = '0;
   logic [BYTE_W-1:0]      held_x = '0;
   logic [POINTER_W-1:0]   cur_col = '0;
   logic [POINTER_W-1:0]   cur_row = '0;
   config_type             screen_cfg;

   mouse_report_type       pending_reports[$];

   int send_idle_pct  = 20;
   int recv_stall_pct = 51;
   drift_type drift_x = DRIFT_NONE;
   drift_type drift_y = DRIFT_NONE;

   int cycle_count     = 0;
   int mismatches      = 0;
   int bytes_sent      = 0;
   int bytes_taken     = 0;
   int packets_checked = 0;
   int overflow_seen   = 0;
   int csr_writes      = 0;

   ps2_mouse_packet_cursor_tracker_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_left_button   (rsp_left_button),
      .rsp_right_button  (rsp_right_button),
      .rsp_middle_button (rsp_middle_button),
      .rsp_move_x        (rsp_move_x),
      .rsp_move_y        (rsp_move_y),
      .rsp_x_overflow    (rsp_x_overflow),
      .rsp_y_overflow    (rsp_y_overflow),
      .rsp_pointer_x     (rsp_pointer_x),
      .rsp_pointer_y     (rsp_pointer_y),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #4 clock = ~clock;

   // Hard stop in case a handshake never completes.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("watchdog: cycle limit reached with %0d packets pending",
                  pending_reports.size());
         $display("tb: failure");
         $finish;
      end
   end

   // Drop rsp_ready at random; one assignment per falling edge.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Add the delta, then clamp to 0 .. screen less cursor, with the limit
   // itself held to 0 .. POINTER_MAX.
   function automatic logic [POINTER_W-1:0] fit_to_screen(input int pos, input int delta,
                                                          input int screen, input int cursor);
      int lim;
      int p;
      lim = screen - cursor;
      p = pos + delta;
      if (lim < 0) lim = 0;
      if (lim > int'(POINTER_MAX)) lim = int'(POINTER_MAX);
      if (p < 0) p = 0;
      else if (p > lim) p = lim;
      return POINTER_W'(p);
   endfunction

   // Advance the shadow decoder by one accepted byte; done marks a finished packet.
   function automatic void decode_mouse_byte(input logic [BYTE_W-1:0] b,
                                             output mouse_report_type rep, output bit done);
      int dx;
      int dy;
      rep  = '0;
      done = 1'b0;
      dx   = 0;
      dy   = 0;
      case (pkt_phase)
         WAIT_X: begin
            held_x = b;
            pkt_phase = WAIT_Y;
            bytes_taken++;
         end
         WAIT_Y: begin
            rep.left   = held_header[LEFT_BIT];
            rep.right  = held_header[RIGHT_BIT];
            rep.middle = held_header[MIDDLE_BIT];
            rep.x_ovf  = held_header[X_OVF_BIT];
            rep.y_ovf  = held_header[Y_OVF_BIT];
            if (!rep.x_ovf && !rep.y_ovf) begin
               dx = int'(held_x) - (held_header[X_SIGN_BIT] ? (1 << BYTE_W) : 0);
               dy = int'(b) - (held_header[Y_SIGN_BIT] ? (1 << BYTE_W) : 0);
               cur_col = fit_to_screen(int'(cur_col), dx, int'(screen_cfg.screen_width),
                                       int'(screen_cfg.cursor_width));
               // screen rows run downward, so up movement lowers the row
               cur_row = fit_to_screen(int'(cur_row), -dy, int'(screen_cfg.screen_height),
                                       int'(screen_cfg.cursor_height));
            end
            rep.move_x = MOVE_W'(dx);
            rep.move_y = MOVE_W'(dy);
            rep.px = cur_col;
            rep.py = cur_row;
            pkt_phase = WAIT_HEADER;
            done = 1'b1;
            bytes_taken++;
         end
         default: begin
            // hunt for a header; anything without the sync bit is dropped
            if (b[SYNC_BIT]) begin
               held_header = b;
               pkt_phase = WAIT_X;
               bytes_taken++;
            end else begin
               pkt_phase = WAIT_HEADER;
            end
         end
      endcase
   endfunction

   // Present one byte, hold it until the transfer, then step the shadow decoder.
   // A pinned row queues its typed report in place of the predicted one.
   task automatic push_byte(input logic [BYTE_W-1:0] b, input logic pinned,
                            input mouse_report_type want);
      mouse_report_type rep;
      bit done;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      bytes_sent++;
      decode_mouse_byte(b, rep, done);
      if (done) pending_reports.push_back(pinned ? want : rep);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      csr_writes++;
      case (csr_index_type'(idx))
         CSR_SCREEN_WIDTH:  screen_cfg.screen_width  = data;
         CSR_SCREEN_HEIGHT: screen_cfg.screen_height = data;
         CSR_CURSOR_WIDTH:  screen_cfg.cursor_width  = data[CURSOR_W-1:0];
         CSR_CURSOR_HEIGHT: screen_cfg.cursor_height = data[CURSOR_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Load a screen setting. Cursor writes carry junk above bit 4, which the
   // block must mask; a write to an unused index follows and must not stick.
   task automatic load_screen(input int sw, input int sh, input int cw, input int ch,
                              input logic [CSR_INDEX_W-1:0] stray_index);
      logic [CSR_DATA_W-1:0] junk;
      junk = CSR_DATA_W'($urandom);
      csr_write(CSR_SCREEN_WIDTH, CSR_DATA_W'(sw));
      csr_write(CSR_SCREEN_HEIGHT, CSR_DATA_W'(sh));
      csr_write(CSR_CURSOR_WIDTH, {junk[CSR_DATA_W-1:CURSOR_W], CURSOR_W'(cw)});
      junk = CSR_DATA_W'($urandom);
      csr_write(CSR_CURSOR_HEIGHT, {junk[CSR_DATA_W-1:CURSOR_W], CURSOR_W'(ch)});
      csr_write(stray_index, CSR_DATA_W'($urandom));
   endtask

   // Drop valid and let every queued report come back, then let the block settle
   // so it is quiet before any register changes.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Random packet (cut after the X byte unless complete); sign bits lean toward the
   // current drift so the cursor reaches the far edges of big screens.
   task automatic send_random_packet(input bit complete);
      logic [BYTE_W-1:0] head;
      head = BYTE_W'($urandom);
      head[SYNC_BIT] = 1'b1;
      if ($urandom_range(7) != 0) begin
         head[X_OVF_BIT] = 1'b0;
         head[Y_OVF_BIT] = 1'b0;
      end
      if (drift_x != DRIFT_NONE && $urandom_range(9) < 8)
         head[X_SIGN_BIT] = (drift_x == DRIFT_DOWN);
      if (drift_y != DRIFT_NONE && $urandom_range(9) < 8)
         head[Y_SIGN_BIT] = (drift_y == DRIFT_DOWN);
      push_byte(head, 1'b0, NO_REPORT);
      push_byte(BYTE_W'($urandom), 1'b0, NO_REPORT);
      if (complete) push_byte(BYTE_W'($urandom), 1'b0, NO_REPORT);
   endtask

   task automatic compare_field(input string name, input logic signed [31:0] want_v,
                                input logic signed [31:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0d, got %0d", name, want_v, got_v);
         mismatches++;
      end
   endtask

   // Check each result transfer against the oldest queued report.
   always @(posedge clock) begin : result_check
      mouse_report_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            $error("result transfer with no packet pending");
            mismatches++;
         end else begin
            want = pending_reports.pop_front();
            compare_field("left_button", 32'(want.left), 32'(rsp_left_button));
            compare_field("right_button", 32'(want.right), 32'(rsp_right_button));
            compare_field("middle_button", 32'(want.middle), 32'(rsp_middle_button));
            compare_field("move_x", 32'($signed(want.move_x)), 32'(rsp_move_x));
            compare_field("move_y", 32'($signed(want.move_y)), 32'(rsp_move_y));
            compare_field("x_overflow", 32'(want.x_ovf), 32'(rsp_x_overflow));
            compare_field("y_overflow", 32'(want.y_ovf), 32'(rsp_y_overflow));
            compare_field("pointer_x", 32'(want.px), 32'(rsp_pointer_x));
            compare_field("pointer_y", 32'(want.py), 32'(rsp_pointer_y));
            packets_checked++;
            if (want.x_ovf || want.y_ovf) overflow_seen++;
         end
      end
   end

   initial begin : stimulus
      int seg;
      int mark;
      int pick;
      int packets_sent;
      logic [CSR_INDEX_W-1:0] stray;

      screen_cfg = {SCREEN_WIDTH_RESET, SCREEN_HEIGHT_RESET,
                    CURSOR_WIDTH_RESET, CURSOR_HEIGHT_RESET};
      packets_sent = 0;

      // hold reset, then release it on a falling edge
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table against the reset defaults
      for (int i = 0; i < DIRECTED_COUNT; i++)
         push_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].want);

      for (seg = 0; seg < SEGMENTS; seg++) begin
         wait_drained();
         stray = (seg == 0) ? {CSR_INDEX_W{1'b1}}
                            : CSR_INDEX_W'($urandom_range(CSR_REG_COUNT,
                                                          (1 << CSR_INDEX_W) - 1));
         case (seg)
            0: load_screen(640, 480, 16, 16, stray);
            1: load_screen(4096, 4096, 1, 1, stray);      // limit lands on 4095
            2: load_screen(8191, 8191, 0, 0, stray);      // limit saturates at 4095
            3: load_screen(32, 32, 31, 31, stray);        // one-pixel travel
            4: load_screen(10, 5, 31, 31, stray);         // cursor wider than screen
            default: load_screen($urandom_range(32, 4096), $urandom_range(32, 4096),
                                 $urandom_range(1, 31), $urandom_range(1, 31), stray);
         endcase

         // receiver stalls harder first, then the sender idles more, then full rate
         case (seg / 2)
            0: begin send_idle_pct = 20; recv_stall_pct = 51; end
            1: begin send_idle_pct = 51; recv_stall_pct = 20; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase

         mark = bytes_taken;
         while (bytes_taken - mark < SEGMENT_BYTES) begin
            pick = $urandom_range(99);
            if (pick < 10) push_byte(BYTE_W'($urandom), 1'b0, NO_REPORT);
            else if (pick < 15) send_random_packet(1'b0);
            else send_random_packet(1'b1);
            packets_sent++;
            if (packets_sent % DRIFT_PERIOD == 0) begin
               drift_x = drift_type'($urandom_range(2));
               drift_y = drift_type'($urandom_range(2));
            end
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);

      $display("summary: %0d bytes sent (%0d dropped), %0d packets checked, %0d with overflow",
               bytes_sent, bytes_sent - bytes_taken, packets_checked, overflow_seen);
      $display("summary: %0d register writes over %0d screen settings and three stall mixes",
               csr_writes, SEGMENTS + 1);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/pmct_pkg.sv
sv/pmct_front.sv
sv/pmct_queue.sv
sv/pmct_back.sv
sv/ps2_mouse_packet_cursor_tracker_unit.sv
sv/pmct_checker.sv
sim/tb_top.sv
